@@ hw/rtl/pqsr_pkg.sv @@
// Types and constants shared by the priority queue modules.
package pqsr_pkg;

   localparam int ACT_W  = 2;
   localparam int PAY_W  = 16;
   localparam int PRIO_W = 8;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 5;

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQ = 2'd0,
      ACT_DEQ = 2'd1,
      ACT_CLR = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [PAY_W-1:0]  payload;
   } entry_type;

endpackage

@@ hw/rtl/pqsr_store.sv @@
// Entry memory with one write port and one registered read port.
module pqsr_store
   import pqsr_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic      clock,
   input  logic      wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type wr_data,
   input  logic      rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/priority_queue_scan_remove_top.sv @@
// Top level of the bounded priority queue held as an unsorted array.
//
// An item is taken when start is high and busy is low, and exactly one result beat
// follows on the rsp_ ports, marked by rsp_valid for a single cycle; the receiver
// cannot stall it. Enqueue, clear, the unused action code and a dequeue on an empty
// queue never leave the idle state, so busy stays low and the result appears in the cycle after the item was taken.
// A dequeue on a non-empty queue reads the entry memory once per entry to find the
// highest priority, then moves each entry after the winner down one place through
// the same memory, and busy stays high until the result is loaded. Both passes go
// through the single memory read port. Ties go to the earliest entry.
module priority_queue_scan_remove_top
   import pqsr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [PAY_W-1:0]  req_payload,
   input  logic [PRIO_W-1:0] req_priority_req,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] rsp_status,
   output logic [PAY_W-1:0]  rsp_removed_payload,
   output logic [CNT_W-1:0]  rsp_entry_count,
   output logic              rsp_queue_empty,
   output logic              rsp_queue_full
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]     best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [PAY_W-1:0]  best_pay_ff, best_pay_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PAY_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_empty_ff, rsp_full_ff;
   logic              rsp_load;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data, rd_data;

   logic [CW-1:0]     last_cnt;
   logic              take;
   logic [AW-1:0]     fin_idx;
   logic [PAY_W-1:0]  fin_pay;

   pqsr_store #(
      .DEPTH(CAPACITY),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign last_cnt = count_ff - CW'(1);
   assign take     = (cmp_idx_ff == '0) || (rd_data.prio > best_prio_ff);
   assign fin_idx  = take ? cmp_idx_ff : best_idx_ff;
   assign fin_pay  = take ? rd_data.payload : best_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_pay_ff  <= best_pay_in;
      wr_ptr_ff    <= wr_ptr_in;
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_count_ff   <= CNT_W'(count_in);
         rsp_empty_ff   <= (count_in == '0);
         rsp_full_ff    <= (count_in == CW'(CAPACITY));
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cmp_idx_in     = cmp_idx_ff;
      best_idx_in    = best_idx_ff;
      best_prio_in   = best_prio_ff;
      best_pay_in    = best_pay_ff;
      wr_ptr_in      = wr_ptr_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '{prio: req_priority_req, payload: req_payload};
      rd_en          = 1'b0;
      rd_addr        = '0;
      rsp_load       = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_removed_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_ENQ: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        cmp_idx_in = '0;
                        state_in   = ST_SCAN;
                     end
                  end
                  ACT_CLR: begin
                     rsp_load = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            best_idx_in  = fin_idx;
            best_pay_in  = fin_pay;
            best_prio_in = take ? rd_data.prio : best_prio_ff;
            if (CW'(cmp_idx_ff) == last_cnt) begin
               if (CW'(fin_idx) == last_cnt) begin
                  count_in       = last_cnt;
                  rsp_load       = 1'b1;
                  rsp_removed_in = fin_pay;
                  state_in       = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = fin_idx + AW'(1);
                  wr_ptr_in = fin_idx;
                  state_in  = ST_SHIFT;
               end
            end else begin
               rd_en      = 1'b1;
               rd_addr    = cmp_idx_ff + AW'(1);
               cmp_idx_in = cmp_idx_ff + AW'(1);
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = wr_ptr_ff;
            wr_data = rd_data;
            if (CW'(wr_ptr_ff) == count_ff - CW'(2)) begin
               count_in       = last_cnt;
               rsp_load       = 1'b1;
               rsp_removed_in = best_pay_ff;
               state_in       = ST_IDLE;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = wr_ptr_ff + AW'(2);
               wr_ptr_in = wr_ptr_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_removed_payload = rsp_removed_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_queue_empty     = rsp_empty_ff;
   assign rsp_queue_full      = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("Entry count exceeds the capacity.");

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff != '0))
      else $error("Dequeue in progress on an empty queue.");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (CW'(wr_ptr_ff) < last_cnt))
      else $error("Shift writes beyond the held entries.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_empty == (count_ff == '0)))
      else $error("Empty flag disagrees with the held count.");

   a_deq_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_DEQ && count_ff != '0) |=> busy)
      else $error("Dequeue on a non-empty queue did not start a scan.");

endmodule
